### hdl/phfa_pkg.sv
// ----------------------------------------------------------------------------
// phfa_pkg
// Shared types and constants of the page heap fit allocator.
// ----------------------------------------------------------------------------
package phfa_pkg;

  localparam int HEAP_PAGES = 1024;
  localparam int PAGE_W     = 10;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 12;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_IGNORED    = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [CNT_W-1:0]  page_count;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] result_page;
    logic [CNT_W-1:0]  break_page;
  } rsp_t;

  typedef struct packed {
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0]  pages;
  } region_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_REMOVE,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    region_t  ins;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_DEC,
    S_F_READ,
    S_F_SCAN,
    S_F_MERGE,
    S_F_REM2,
    S_INSERT,
    S_F_BRK,
    S_F_SET,
    S_F_DROP,
    S_DONE
  } state_t;

endpackage

### hdl/page_heap_fit_allocator.sv
// ----------------------------------------------------------------------------
// page_heap_fit_allocator
// Page heap allocator with an exact-then-worst-fit free-region list.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-entry size table, one entry a cycle,
// and stalls input until the clear is done. Each transaction is then handled
// alone: an allocate scans every free region on the list once, and a free
// scans the list, then walks the size table down page by page from the break
// to the highest remaining allocation, then makes a pruning pass over the
// list. The scans take this shape because the region list is a chain of cells
// scanned by rotation, one region per cycle, and the size table has one read
// port. A finished result sits in an output register, so the next transaction
// is taken while the previous result waits.
module page_heap_fit_allocator #(
  parameter int MAX_FREE_REGIONS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [9:0]      cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  phfa_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output phfa_pkg::rsp_t  out_data
);
  import phfa_pkg::*;

  localparam int IW = $clog2(MAX_FREE_REGIONS);
  localparam int CW = $clog2(MAX_FREE_REGIONS + 1);

  cell_ctl_t     cell_ctl;
  logic [IW-1:0] cell_at;
  logic [CW-1:0] rcount;
  region_t       cells [MAX_FREE_REGIONS];

  phfa_ctrl #(
    .MAX_FREE_REGIONS(MAX_FREE_REGIONS),
    .IW(IW),
    .CW(CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cell_ctl   (cell_ctl),
    .cell_at    (cell_at),
    .rcount     (rcount),
    .head       (cells[0])
  );

  for (genvar j = 0; j < MAX_FREE_REGIONS; j++) begin : g_cell
    region_t left_in, right_in;
    if (j == 0) begin : g_first
      assign left_in = cells[0];
    end else begin : g_mid
      assign left_in = cells[j-1];
    end
    if (j == MAX_FREE_REGIONS - 1) begin : g_last
      assign right_in = cells[j];
    end else begin : g_next
      assign right_in = cells[j+1];
    end

    phfa_cell #(
      .IW(IW),
      .CW(CW)
    ) u_cell (
      .clk  (clk),
      .pos  (IW'(j)),
      .count(rcount),
      .at   (cell_at),
      .ctl  (cell_ctl),
      .head (cells[0]),
      .left (left_in),
      .right(right_in),
      .q    (cells[j])
    );
  end

endmodule

### hdl/phfa_cell.sv
// ----------------------------------------------------------------------------
// phfa_cell
// One slot of the free-region list: holds a region and moves it to or from
// its neighbors on rotate, remove and sorted insert.
// ----------------------------------------------------------------------------
module phfa_cell #(
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic              clk,
  input  logic [IW-1:0]     pos,
  input  logic [CW-1:0]     count,
  input  logic [IW-1:0]     at,
  input  phfa_pkg::cell_ctl_t ctl,
  input  phfa_pkg::region_t head,
  input  phfa_pkg::region_t left,
  input  phfa_pkg::region_t right,
  output phfa_pkg::region_t q
);
  import phfa_pkg::*;

  logic [CW-1:0] pos_ext;
  logic          own_valid;
  logic          own_gt;
  logic          left_gt;
  region_t       q_next;

  assign pos_ext   = CW'(pos);
  assign own_valid = pos_ext < count;
  assign own_gt    = own_valid && (q.pages > ctl.ins.pages);
  assign left_gt   = (pos_ext <= count) && (left.pages > ctl.ins.pages);

  always_comb begin
    q_next = q;
    unique case (ctl.op)
      OP_ROTATE: begin
        if (pos_ext == count - CW'(1)) begin
          q_next = head;
        end else if (own_valid) begin
          q_next = right;
        end
      end
      OP_REMOVE: begin
        if (pos >= at) begin
          q_next = right;
        end
      end
      OP_INSERT: begin
        // equal sizes shift right so the new region lands first
        if (own_gt) begin
          q_next = q;
        end else if (pos_ext == '0 || left_gt) begin
          q_next = ctl.ins;
        end else if (pos_ext <= count) begin
          q_next = left;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

### hdl/phfa_ctrl.sv
// ----------------------------------------------------------------------------
// phfa_ctrl
// Sequencer of the allocator: size table, break, scans over the region chain
// and the result register.
// ----------------------------------------------------------------------------
module phfa_ctrl #(
  parameter int MAX_FREE_REGIONS = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [9:0]              cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  phfa_pkg::req_t          in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output phfa_pkg::rsp_t          out_data,
  output phfa_pkg::cell_ctl_t     cell_ctl,
  output logic [IW-1:0]           cell_at,
  output logic [CW-1:0]           rcount,
  input  phfa_pkg::region_t       head
);
  import phfa_pkg::*;

  localparam logic [CW-1:0]    MAX_C  = CW'(MAX_FREE_REGIONS);
  localparam logic [SUM_W-1:0] HEAP_S = SUM_W'(HEAP_PAGES);

  state_t state, state_next;

  logic [CNT_W-1:0]  size_mem [HEAP_PAGES];
  logic [CNT_W-1:0]  rd_data;
  logic [PAGE_W-1:0] rd_addr;
  logic              mem_we;
  logic [PAGE_W-1:0] mem_wa;
  logic [CNT_W-1:0]  mem_wd;

  logic [CW-1:0]     rcount_next;
  logic [CNT_W-1:0]  off, off_next;
  logic [PAGE_W-1:0] start;
  logic [PAGE_W-1:0] clr_ptr;
  logic              load;

  cmd_t              cmd;
  logic [CNT_W-1:0]  cnt;
  logic [PAGE_W-1:0] p;
  logic [CNT_W-1:0]  size;
  logic [IW-1:0]     scan_i;
  logic [CW-1:0]     remain;
  logic              found;
  logic [IW-1:0]     m;
  logic [PAGE_W-1:0] mfirst;
  region_t           hreg;
  logic              has_lo, has_hi;
  logic [IW-1:0]     lo, hi;
  logic [PAGE_W-1:0] lofirst;
  logic [CNT_W-1:0]  lopages, hipages;
  region_t           ins;
  logic              ins_ret;
  status_t           status;
  logic [PAGE_W-1:0] page;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  ptr_dec;
  logic              pend;
  logic [PAGE_W-1:0] paddr;
  logic [SUM_W-1:0]  newb;
  logic [SUM_W-1:0]  nb;

  logic [SUM_W-1:0]  brk;
  logic [CNT_W-1:0]  cur_brk;
  logic              brk_fail;
  logic              split_ok;
  logic [CNT_W-1:0]  off_set;
  logic [SUM_W-1:0]  head_end;
  logic [SUM_W-1:0]  free_end;

  assign brk      = SUM_W'(start) + SUM_W'(off);
  assign cur_brk  = (brk > HEAP_S) ? CNT_W'(HEAP_PAGES) : brk[CNT_W-1:0];
  assign brk_fail = (brk >= HEAP_S) || (SUM_W'(cnt) > HEAP_S - brk);
  assign split_ok = (rcount != '0) && (hreg.pages > cnt);
  assign off_set  = (newb > SUM_W'(start)) ? CNT_W'(newb - SUM_W'(start)) : '0;
  assign head_end = SUM_W'(head.first) + SUM_W'(head.pages);
  assign free_end = SUM_W'(p) + SUM_W'(size);
  assign ptr_dec  = ptr - CNT_W'(1);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[mem_wa] <= mem_wd;
    end
    rd_data <= size_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    cell_ctl.op  = OP_HOLD;
    cell_ctl.ins = ins;
    cell_at  = '0;
    mem_we   = 1'b0;
    mem_wa   = p;
    mem_wd   = '0;
    rd_addr  = in_data.page_index;
    off_next = off;
    load     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_ptr;
        if (clr_ptr == PAGE_W'(HEAP_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_ALLOC) begin
            if (in_data.page_count == '0) begin
              state_next = S_DONE;
            end else if (rcount == '0) begin
              state_next = S_A_DEC;
            end else begin
              state_next = S_A_SCAN;
            end
          end else if (in_data.page_index < start) begin
            state_next = S_DONE;
          end else begin
            state_next = S_F_READ;
          end
        end
      end
      S_A_SCAN: begin
        cell_ctl.op = OP_ROTATE;
        if (remain == CW'(1)) begin
          state_next = S_A_DEC;
        end
      end
      S_A_DEC: begin
        mem_wd = cnt;
        if (found) begin
          cell_ctl.op = OP_REMOVE;
          cell_at     = m;
          mem_we      = 1'b1;
          mem_wa      = mfirst;
          state_next  = S_DONE;
        end else if (split_ok) begin
          cell_ctl.op = OP_REMOVE;
          mem_we      = 1'b1;
          mem_wa      = hreg.first;
          state_next  = S_INSERT;
        end else if (brk_fail) begin
          state_next = S_DONE;
        end else begin
          mem_we     = 1'b1;
          mem_wa     = brk[PAGE_W-1:0];
          off_next   = off + cnt;
          state_next = S_DONE;
        end
      end
      S_F_READ: begin
        if (rd_data == '0) begin
          state_next = S_DONE;
        end else begin
          mem_we     = 1'b1;
          state_next = (rcount == '0) ? S_F_MERGE : S_F_SCAN;
        end
      end
      S_F_SCAN: begin
        cell_ctl.op = OP_ROTATE;
        if (remain == CW'(1)) begin
          state_next = S_F_MERGE;
        end
      end
      S_F_MERGE: begin
        state_next = S_INSERT;
        if (has_lo && has_hi && lo != hi) begin
          cell_ctl.op = OP_REMOVE;
          cell_at     = (lo > hi) ? lo : hi;
          state_next  = S_F_REM2;
        end else if (has_lo) begin
          cell_ctl.op = OP_REMOVE;
          cell_at     = lo;
        end else if (has_hi) begin
          cell_ctl.op = OP_REMOVE;
          cell_at     = hi;
        end
      end
      S_F_REM2: begin
        cell_ctl.op = OP_REMOVE;
        cell_at     = (lo > hi) ? hi : lo;
        state_next  = S_INSERT;
      end
      S_INSERT: begin
        if (rcount != MAX_C) begin
          cell_ctl.op = OP_INSERT;
        end
        state_next = ins_ret ? S_F_BRK : S_DONE;
      end
      S_F_BRK: begin
        // one size entry read per cycle, walking down from the break
        rd_addr = ptr_dec[PAGE_W-1:0];
        if ((pend && rd_data != '0) || ptr == '0) begin
          state_next = S_F_SET;
        end
      end
      S_F_SET: begin
        off_next   = off_set;
        state_next = (rcount == '0) ? S_DONE : S_F_DROP;
      end
      S_F_DROP: begin
        cell_ctl.op = (SUM_W'(head.first) >= nb) ? OP_REMOVE : OP_ROTATE;
        if (remain == CW'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (cell_ctl.op)
      OP_REMOVE: rcount_next = rcount - CW'(1);
      OP_INSERT: rcount_next = rcount + CW'(1);
      default:   rcount_next = rcount;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rcount    <= '0;
      off       <= '0;
      start     <= '0;
      clr_ptr   <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rcount <= rcount_next;
      off    <= off_next;
      if (cfg_wr_en) begin
        start <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_ptr <= clr_ptr + PAGE_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd     <= in_data.command;
        cnt     <= in_data.page_count;
        p       <= in_data.page_index;
        remain  <= rcount;
        scan_i  <= '0;
        found   <= 1'b0;
        has_lo  <= 1'b0;
        has_hi  <= 1'b0;
        hreg    <= head;
        page    <= '0;
        ins_ret <= (in_data.command == CMD_FREE);
        if (in_data.command == CMD_ALLOC) begin
          status <= (in_data.page_count == '0) ? ST_NO_SPACE : ST_OK;
        end else begin
          status <= (in_data.page_index < start) ? ST_IGNORED : ST_OK;
        end
      end
      S_A_SCAN: begin
        if (!found && head.pages == cnt) begin
          found  <= 1'b1;
          m      <= scan_i;
          mfirst <= head.first;
        end
        scan_i <= scan_i + IW'(1);
        remain <= remain - CW'(1);
      end
      S_A_DEC: begin
        if (found) begin
          page <= mfirst;
        end else if (split_ok) begin
          page      <= hreg.first;
          ins.first <= hreg.first + cnt[PAGE_W-1:0];
          ins.pages <= hreg.pages - cnt;
        end else if (brk_fail) begin
          status <= ST_NO_SPACE;
        end else begin
          page <= brk[PAGE_W-1:0];
        end
      end
      S_F_READ: begin
        size <= rd_data;
        if (rd_data == '0) begin
          status <= ST_IGNORED;
        end
      end
      S_F_SCAN: begin
        // last match in list order wins on each side
        if (head_end == SUM_W'(p)) begin
          has_lo  <= 1'b1;
          lo      <= scan_i;
          lofirst <= head.first;
          lopages <= head.pages;
        end
        if (SUM_W'(head.first) == free_end) begin
          has_hi  <= 1'b1;
          hi      <= scan_i;
          hipages <= head.pages;
        end
        scan_i <= scan_i + IW'(1);
        remain <= remain - CW'(1);
      end
      S_F_MERGE: begin
        if (has_lo && has_hi && lo != hi) begin
          ins.first <= lofirst;
          ins.pages <= lopages + size + hipages;
        end else if (has_lo) begin
          ins.first <= lofirst;
          ins.pages <= lopages + size;
        end else if (has_hi) begin
          ins.first <= p;
          ins.pages <= hipages + size;
        end else begin
          ins.first <= p;
          ins.pages <= size;
        end
      end
      S_INSERT: begin
        if (rcount == MAX_C) begin
          status <= ST_TABLE_FULL;
        end
        ptr  <= cur_brk;
        pend <= 1'b0;
      end
      S_F_BRK: begin
        if (pend && rd_data != '0) begin
          newb <= SUM_W'(paddr) + SUM_W'(rd_data);
        end else if (ptr == '0) begin
          newb <= SUM_W'(start);
        end else begin
          paddr <= ptr_dec[PAGE_W-1:0];
          pend  <= 1'b1;
          ptr   <= ptr_dec;
        end
      end
      S_F_SET: begin
        nb     <= SUM_W'(start) + SUM_W'(off_set);
        remain <= rcount;
      end
      S_F_DROP: begin
        remain <= remain - CW'(1);
      end
      S_DONE: begin
        if (load) begin
          out_data.status      <= status;
          out_data.result_page <= (cmd == CMD_ALLOC) ? page : '0;
          out_data.break_page  <= cur_brk;
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= MAX_C)
    else $error("region count above table size");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT && rcount != MAX_C) |=> rcount == $past(rcount) + CW'(1))
    else $error("insert did not grow the region list");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SCAN || state == S_F_SCAN || state == S_F_DROP) |-> rcount != '0)
    else $error("chain scan on an empty region list");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result loaded but not presented");

endmodule

### dv/tb_page_heap_fit_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_heap_fit_allocator
// Self-checking bench: directed table, table-full corner, random alloc/free
// traffic, checked against a behavioral allocator model kept in the bench.
// ----------------------------------------------------------------------------
module tb_page_heap_fit_allocator;
  import phfa_pkg::*;

  localparam int NREG = 64;
  localparam int LIMIT = 3000000;

  logic clk, rst;
  logic cfg_wr_en;
  logic [9:0] cfg_wr_data;
  logic in_valid, in_stall, out_valid, out_stall;
  req_t in_data;
  rsp_t out_data;

  page_heap_fit_allocator u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // allocator model state
  int unsigned sizes[HEAP_PAGES];
  int unsigned rfirst[NREG];
  int unsigned rpages[NREG];
  int unsigned rcount, brk_off, region_start;
  int unsigned live_pages[$];

  rsp_t expected_rsp[$];
  int errors;
  int src_idle, rcv_stall;
  longint cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned break_now();
    int unsigned b;
    b = region_start + brk_off;
    return b > HEAP_PAGES ? HEAP_PAGES : b;
  endfunction

  function automatic void region_drop(int unsigned at);
    if (at >= rcount) return;
    for (int unsigned i = at; i + 1 < rcount; i++) begin
      rfirst[i] = rfirst[i+1];
      rpages[i] = rpages[i+1];
    end
    rcount--;
  endfunction

  function automatic bit region_add(int unsigned first, int unsigned pages);
    int unsigned pos;
    pos = 0;
    if (rcount >= NREG) return 0;
    while (pos < rcount && rpages[pos] > pages) pos++;
    for (int unsigned i = rcount; i > pos; i--) begin
      rfirst[i] = rfirst[i-1];
      rpages[i] = rpages[i-1];
    end
    rfirst[pos] = first;
    rpages[pos] = pages;
    rcount++;
    return 1;
  endfunction

  function automatic bit grant_pages(int unsigned n, output int unsigned pg);
    int unsigned b, first, rest;
    bit ok;
    pg = 0;
    if (n == 0) return 0;
    for (int unsigned i = 0; i < rcount; i++)
      if (rpages[i] == n && rfirst[i] < HEAP_PAGES) begin
        pg = rfirst[i];
        region_drop(i);
        sizes[pg] = n;
        return 1;
      end
    if (rcount > 0 && rpages[0] > n && rfirst[0] < HEAP_PAGES) begin
      first = rfirst[0];
      rest = rpages[0] - n;
      region_drop(0);
      ok = region_add(first + n, rest);
      pg = first;
      sizes[first] = n;
      return 1;
    end
    b = region_start + brk_off;
    if (b >= HEAP_PAGES || n > HEAP_PAGES - b) return 0;
    pg = b;
    sizes[b] = n;
    brk_off += n;
    return 1;
  endfunction

  function automatic status_t release_pages(int unsigned p);
    int unsigned sz, lo, hi, first, total, b, nb, i;
    bit has_lo, has_hi, ok;
    status_t st;
    st = ST_OK;
    has_lo = 0; has_hi = 0; lo = 0; hi = 0;
    if (p < region_start || p >= HEAP_PAGES) return ST_IGNORED;
    sz = sizes[p];
    if (sz == 0) return ST_IGNORED;
    sizes[p] = 0;
    for (i = 0; i < rcount; i++) begin
      if (rfirst[i] + rpages[i] == p) begin has_lo = 1; lo = i; end
      if (rfirst[i] == p + sz) begin has_hi = 1; hi = i; end
    end
    if (has_lo && has_hi && lo != hi) begin
      first = rfirst[lo];
      total = rpages[lo] + sz + rpages[hi];
      if (lo > hi) begin region_drop(lo); region_drop(hi); end
      else begin region_drop(hi); region_drop(lo); end
      ok = region_add(first, total);
    end else if (has_lo) begin
      first = rfirst[lo];
      total = rpages[lo] + sz;
      region_drop(lo);
      ok = region_add(first, total);
    end else if (has_hi) begin
      total = rpages[hi] + sz;
      region_drop(hi);
      ok = region_add(p, total);
    end else if (!region_add(p, sz)) begin
      st = ST_TABLE_FULL;
    end
    b = break_now();
    nb = region_start;
    for (i = b; i > 0; i--)
      if (sizes[i-1] != 0) begin
        nb = (i - 1) + sizes[i-1];
        break;
      end
    brk_off = nb > region_start ? nb - region_start : 0;
    nb = region_start + brk_off;
    i = 0;
    while (i < rcount)
      if (rfirst[i] >= nb) region_drop(i);
      else i++;
    return st;
  endfunction

  function automatic rsp_t heap_step(req_t r);
    rsp_t o;
    int unsigned pg;
    pg = 0;
    o = '0;
    if (r.command == CMD_ALLOC) begin
      if (grant_pages(r.page_count, pg)) begin
        o.status = ST_OK;
        o.result_page = pg[9:0];
        live_pages.push_back(pg);
      end else o.status = ST_NO_SPACE;
    end else begin
      o.status = release_pages(r.page_index);
    end
    o.break_page = CNT_W'(break_now());
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      cycles++;
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) report_mismatch("unexpected transaction", 1, 0);
        else begin
          e = expected_rsp.pop_front();
          if (out_data.status !== e.status)
            report_mismatch("status", out_data.status, e.status);
          if (out_data.result_page !== e.result_page)
            report_mismatch("result_page", out_data.result_page, e.result_page);
          if (out_data.break_page !== e.break_page)
            report_mismatch("break_page", out_data.break_page, e.break_page);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall);
    end
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    if ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = heap_step(r);
    if (typed && p !== typed_rsp) report_mismatch("directed table row", p, typed_rsp);
    expected_rsp.push_back(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic set_region_start(int unsigned v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[9:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    region_start = v;
  endtask

  function automatic req_t mk(cmd_t c, int unsigned n, int unsigned p);
    req_t r;
    r.command = c;
    r.page_count = n[10:0];
    r.page_index = p[9:0];
    return r;
  endfunction

  function automatic rsp_t mr(status_t s, int unsigned pg, int unsigned b);
    rsp_t o;
    o.status = s;
    o.result_page = pg[9:0];
    o.break_page = b[10:0];
    return o;
  endfunction

  typedef struct {
    req_t r;
    bit typed;
    rsp_t o;
  } row_t;

  task automatic random_phase(int n, int idle, int stall);
    req_t r;
    int unsigned k, p;
    src_idle = idle;
    rcv_stall = stall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        case ($urandom_range(9))
          0: p = $urandom_range(1024, 1);
          1: p = $urandom_range(2047, 0);
          default: p = $urandom_range(24, 1);
        endcase
        r = mk(CMD_ALLOC, p, $urandom_range(1023));
      end else if (k < 88 && live_pages.size() != 0) begin
        p = $urandom_range(live_pages.size() - 1);
        r = mk(CMD_FREE, $urandom_range(2047), live_pages[p]);
        live_pages.delete(p);
      end else begin
        r = mk(CMD_FREE, $urandom_range(2047), $urandom_range(1023));
      end
      send(r, 0, '0);
    end
  endtask

  initial begin
    row_t rows[$];
    for (int i = 0; i < HEAP_PAGES; i++) sizes[i] = 0;
    rcount = 0; brk_off = 0; region_start = 0;
    errors = 0; cycles = 0; src_idle = 0; rcv_stall = 0;
    rst = 1; cfg_wr_en = 0; cfg_wr_data = '0;
    in_valid = 0; in_data = '0; out_stall = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed table, region start 0
    rows.push_back('{mk(CMD_ALLOC, 0, 0), 1, mr(ST_NO_SPACE, 0, 0)});
    rows.push_back('{mk(CMD_ALLOC, 1025, 0), 1, mr(ST_NO_SPACE, 0, 0)});
    rows.push_back('{mk(CMD_FREE, 0, 0), 1, mr(ST_IGNORED, 0, 0)});
    rows.push_back('{mk(CMD_ALLOC, 1024, 1023), 1, mr(ST_OK, 0, 1024)});
    rows.push_back('{mk(CMD_ALLOC, 1, 0), 1, mr(ST_NO_SPACE, 0, 1024)});
    rows.push_back('{mk(CMD_FREE, 2047, 0), 1, mr(ST_OK, 0, 0)});
    rows.push_back('{mk(CMD_ALLOC, 4, 0), 0, '0});
    rows.push_back('{mk(CMD_ALLOC, 8, 0), 0, '0});
    rows.push_back('{mk(CMD_ALLOC, 4, 0), 0, '0});
    rows.push_back('{mk(CMD_ALLOC, 2, 0), 0, '0});
    rows.push_back('{mk(CMD_FREE, 0, 4), 0, '0});
    rows.push_back('{mk(CMD_FREE, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_FREE, 0, 12), 0, '0});
    rows.push_back('{mk(CMD_ALLOC, 16, 0), 0, '0});
    rows.push_back('{mk(CMD_ALLOC, 3, 0), 0, '0});
    rows.push_back('{mk(CMD_FREE, 0, 5), 1, mr(ST_IGNORED, 0, 21)});
    rows.push_back('{mk(CMD_FREE, 0, 1023), 0, '0});
    foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].o);

    // table-full corner: many one-page holes separated by live pages
    for (int i = 0; i < 140; i++) send(mk(CMD_ALLOC, 1, 0), 0, '0);
    for (int i = 0; i < 138; i += 2) send(mk(CMD_FREE, 0, 22 + i), 0, '0);
    rcv_stall = 40;
    for (int i = 0; i < 70; i++) send(mk(CMD_FREE, 0, 23 + 2 * i), 0, '0);
    live_pages.delete();
    for (int i = 0; i < HEAP_PAGES; i++) if (sizes[i] != 0) live_pages.push_back(i);

    random_phase(60, 0, 0);
    set_region_start(1023);
    send(mk(CMD_FREE, 0, 1000), 0, '0);
    random_phase(40, 78, 0);
    set_region_start(300);
    random_phase(50, 0, 78);
    set_region_start(0);
    random_phase(50, 18, 18);
    set_region_start(517);
    random_phase(40, 78, 78);

    src_idle = 0;
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
